/* hw/rtl/histogram_accumulator_registers_macros.svh */
// Assertion helpers for the histogram RTL.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef HISTOGRAM_ACCUMULATOR_REGISTERS_MACROS_SVH
`define HISTOGRAM_ACCUMULATOR_REGISTERS_MACROS_SVH

// Same-cycle implication
`define HACR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define HACR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/hacr_pkg.sv */
`default_nettype none

package hacr_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned NUM_BINS_DEF    = 256;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  // Bus register width
  localparam int unsigned DATA_W = 16;

  // Depth of the queue between front and back
  localparam int unsigned QDEPTH = 2;

  // Register map
  localparam logic [1:0] REG_CTRL   = 2'd0;
  localparam logic [1:0] REG_DATA   = 2'd1;
  localparam logic [1:0] REG_STATUS = 2'd2;
  localparam logic [1:0] REG_RESULT = 2'd3;

  // Control register bit positions
  localparam int unsigned CTL_PIXEL_BIT = 0;
  localparam int unsigned CTL_CLEAR_BIT = 1;
  localparam int unsigned CTL_LATCH_BIT = 2;

  // One classified bus access, handed from front to back
  typedef struct packed {
    logic              clear;   // sweep all bins to zero
    logic              pixel;   // increment bin pix_idx (already range checked)
    logic              latch;   // capture bin bin_idx into the result register
    logic              lat_ok;  // bin_idx is inside the histogram
    logic              res_rd;  // read of the result register
    logic [7:0]        pix_idx;
    logic [7:0]        bin_idx;
    logic [DATA_W-1:0] rd_val;  // read value known to the front, zero on writes
  } hacr_op_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } hacr_q_status_t;

endpackage

`default_nettype wire

/* hw/rtl/hacr_fifo.sv */
`default_nettype none

module hacr_fifo import hacr_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire hacr_op_t       op_i,
  input  wire logic           pop_i,
  output hacr_op_t            head_o,
  output hacr_q_status_t      stat_o
);

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  hacr_op_t           entries_q [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               do_push, do_pop;

  assign stat_o.full  = (cnt_q == CNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = entries_q[rd_ptr_q];

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= op_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hacr_front.sv */
`default_nettype none

module hacr_front import hacr_pkg::*; #(
  parameter int unsigned NUM_BINS = NUM_BINS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic              is_write_i,
  input  wire logic [1:0]        reg_index_i,
  input  wire logic [DATA_W-1:0] write_data_i,
  output logic                   full_o,
  input  wire logic              init_busy_i,
  input  wire hacr_q_status_t    q_stat_i,
  output logic                   q_push_o,
  output hacr_op_t               q_op_o
);

  logic [2:0]        ctrl_q, ctrl_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic [2:0]        rising;
  logic [7:0]        pix_idx, bin_idx;

  // Hold off while the bins are being swept after reset
  assign full_o   = q_stat_i.full || init_busy_i;
  assign q_push_o = push_i && !full_o;

  assign rising  = write_data_i[2:0] & ~ctrl_q;
  assign pix_idx = data_q[7:0];
  assign bin_idx = data_q[15:8];

  // Classify the access and update the front-side registers
  always_comb begin
    ctrl_d         = ctrl_q;
    data_d         = data_q;
    q_op_o         = '0;
    q_op_o.pix_idx = pix_idx;
    q_op_o.bin_idx = bin_idx;
    q_op_o.lat_ok  = (32'(bin_idx) < NUM_BINS);
    if (is_write_i) begin
      unique case (reg_index_i)
        REG_CTRL: begin
          ctrl_d       = write_data_i[2:0];
          q_op_o.clear = rising[CTL_CLEAR_BIT];
          q_op_o.pixel = rising[CTL_PIXEL_BIT] && (32'(pix_idx) < NUM_BINS);
          q_op_o.latch = rising[CTL_LATCH_BIT];
        end
        REG_DATA: begin
          data_d = write_data_i;
        end
        REG_STATUS, REG_RESULT: begin
          // read-only registers: write ignored
        end
        default: begin
        end
      endcase
    end else begin
      unique case (reg_index_i)
        REG_CTRL:   q_op_o.rd_val = DATA_W'(ctrl_q);
        REG_DATA:   q_op_o.rd_val = data_q;
        REG_STATUS: q_op_o.rd_val = DATA_W'({ctrl_q[CTL_LATCH_BIT], ctrl_q[CTL_PIXEL_BIT]});
        REG_RESULT: q_op_o.res_rd = 1'b1;
        default:    q_op_o.rd_val = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
      data_q <= '0;
    end else if (q_push_o) begin
      ctrl_q <= ctrl_d;
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hacr_back.sv */
`default_nettype none
`include "histogram_accumulator_registers_macros.svh"

module hacr_back import hacr_pkg::*; #(
  parameter int unsigned NUM_BINS    = NUM_BINS_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hacr_op_t          q_head_i,
  input  wire hacr_q_status_t    q_stat_i,
  output logic                   q_pop_o,
  output logic                   init_busy_o,
  output logic                   out_valid_o,
  output logic [DATA_W-1:0]      out_data_o,
  input  wire logic              pop_i
);

  localparam int unsigned IDX_W = $clog2(NUM_BINS);
  localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(NUM_BINS - 1);

  typedef enum logic [2:0] {
    B_INIT, B_IDLE, B_CLR, B_PIX_RD, B_PIX_WR, B_LAT_RD, B_LAT_CAP, B_EMIT
  } state_e;

  state_e              state_q, state_d;
  hacr_op_t            op_q, op_d, src;
  logic [IDX_W-1:0]    clr_cnt_q, clr_cnt_d;
  logic [DATA_W-1:0]   latched_q, latched_d;
  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   out_data_q, out_data_d;

  logic [COUNT_WIDTH-1:0] bin_mem_q [NUM_BINS];
  logic [COUNT_WIDTH-1:0] rd_data_q;
  logic                   rd_en, wr_en;
  logic [IDX_W-1:0]       rd_addr, wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data, inc_val;
  logic [DATA_W-1:0]      sat_val, fin_data;
  logic                   fin, pop_acc, out_free, out_load;

  assign init_busy_o = (state_q == B_INIT);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign pop_acc  = pop_i && out_valid_q;
  assign out_free = !out_valid_q || pop_acc;

  // Saturating increment and 16-bit view of the read bin
  assign inc_val = (rd_data_q == {COUNT_WIDTH{1'b1}}) ? rd_data_q
                                                       : rd_data_q + COUNT_WIDTH'(1);
  assign sat_val = (32'(rd_data_q) > 32'hFFFF) ? {DATA_W{1'b1}} : DATA_W'(rd_data_q);

  // Result of the access being finished
  assign src      = (state_q == B_IDLE) ? q_head_i : op_q;
  assign fin_data = src.res_rd ? latched_q : src.rd_val;
  assign out_load = fin && out_free;

  // Bin memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bin_mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= bin_mem_q[rd_addr];
    end
  end

  // Sequencer next state
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    clr_cnt_d   = clr_cnt_q;
    latched_d   = latched_q;
    out_valid_d = out_valid_q && !pop_acc;
    out_data_d  = out_data_q;
    q_pop_o     = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;
    fin         = 1'b0;

    unique case (state_q)
      B_INIT: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_q;
        if (clr_cnt_q == CLR_LAST) begin
          state_d = B_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + IDX_W'(1);
        end
      end
      B_IDLE: begin
        if (!q_stat_i.empty) begin
          q_pop_o = 1'b1;
          op_d    = q_head_i;
          // fast path issues the bin read right away
          priority if (q_head_i.clear) begin
            clr_cnt_d = '0;
            state_d   = B_CLR;
          end else if (q_head_i.pixel) begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(q_head_i.pix_idx);
            state_d = B_PIX_WR;
          end else if (q_head_i.latch) begin
            rd_en   = q_head_i.lat_ok;
            rd_addr = IDX_W'(q_head_i.bin_idx);
            state_d = B_LAT_CAP;
          end else begin
            fin = 1'b1;
          end
        end
      end
      B_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_q;
        if (clr_cnt_q == CLR_LAST) begin
          priority if (op_q.pixel) begin
            state_d = B_PIX_RD;
          end else if (op_q.latch) begin
            state_d = B_LAT_RD;
          end else begin
            fin = 1'b1;
          end
        end else begin
          clr_cnt_d = clr_cnt_q + IDX_W'(1);
        end
      end
      B_PIX_RD: begin
        rd_en   = 1'b1;
        rd_addr = IDX_W'(op_q.pix_idx);
        state_d = B_PIX_WR;
      end
      B_PIX_WR: begin
        wr_en   = 1'b1;
        wr_addr = IDX_W'(op_q.pix_idx);
        wr_data = inc_val;
        if (op_q.latch) begin
          state_d = B_LAT_RD;
        end else begin
          fin = 1'b1;
        end
      end
      B_LAT_RD: begin
        rd_en   = op_q.lat_ok;
        rd_addr = IDX_W'(op_q.bin_idx);
        state_d = B_LAT_CAP;
      end
      B_LAT_CAP: begin
        latched_d = op_q.lat_ok ? sat_val : '0;
        fin       = 1'b1;
      end
      B_EMIT: begin
        fin = 1'b1;
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase

    // Hand the result to the output register, or wait for room
    if (fin) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        out_data_d  = fin_data;
        state_d     = B_IDLE;
      end else begin
        state_d = B_EMIT;
      end
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_INIT;
      op_q        <= '0;
      clr_cnt_q   <= '0;
      latched_q   <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      clr_cnt_q   <= clr_cnt_d;
      latched_q   <= latched_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  `HACR_ASSERT_IMPL(a_init_no_pop, state_q == B_INIT, !q_pop_o, "queue popped during init sweep")
  `HACR_ASSERT_IMPL(a_load_needs_room, out_load, !out_valid_q || pop_i, "result overwrote a waiting result")
  `HACR_ASSERT_IMPL(a_pixwr_has_pixel, state_q == B_PIX_WR, op_q.pixel, "bin write without a pixel")
  `HACR_ASSERT_NEXT(a_clr_ends, state_q == B_CLR && clr_cnt_q == CLR_LAST, state_q != B_CLR, "clear sweep overran")

endmodule

`default_nettype wire

/* hw/rtl/histogram_accumulator_registers.sv */
// Pixel histogram with a four-register bus view (control, data, status, result).
// Input channel: one bus access per item on is_write_i, reg_index_i and
// write_data_i, taken when push is high and full is low. Result channel:
// one read_data_o item per access (zero for writes), oldest first, shown
// while empty is low and taken when pop is high.
// Accesses go through a two-entry queue to a sequencer that owns the bin
// memory (one write port, one registered read port). A plain register access
// or a write with no action needs no memory step; a pixel count reads its
// bin and writes it back, a latch reads its bin and captures it, and both
// together do the pixel steps first. The memory port sets the pace: the
// sequencer takes a new access only when it is through with the last one.
// A rising clear bit sweeps the bins, one per cycle, before any pixel count
// or latch in the same write. Reset clears the registers and starts the same
// sweep; full stays high until it ends. When the receiver stalls, the
// finished result is held, one more finished access waits in the sequencer,
// two further accesses queue up, and then full goes high.
`default_nettype none

module histogram_accumulator_registers import hacr_pkg::*; #(
  parameter int unsigned NUM_BINS    = NUM_BINS_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              is_write_i,
  input  wire logic [1:0]        reg_index_i,
  input  wire logic [DATA_W-1:0] write_data_i,
  output logic                   empty,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      read_data_o
);

  hacr_op_t       fe_op, q_head;
  hacr_q_status_t q_stat;
  logic           fe_push, q_pop, init_busy, out_valid;

  // Front: decode accesses, own control and data registers
  hacr_front #(
    .NUM_BINS (NUM_BINS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .is_write_i   (is_write_i),
    .reg_index_i  (reg_index_i),
    .write_data_i (write_data_i),
    .full_o       (full),
    .init_busy_i  (init_busy),
    .q_stat_i     (q_stat),
    .q_push_o     (fe_push),
    .q_op_o       (fe_op)
  );

  // Queue between front and back
  hacr_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fe_push),
    .op_i   (fe_op),
    .pop_i  (q_pop),
    .head_o (q_head),
    .stat_o (q_stat)
  );

  // Back: bin memory sequencer and result register
  hacr_back #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_head_i    (q_head),
    .q_stat_i    (q_stat),
    .q_pop_o     (q_pop),
    .init_busy_o (init_busy),
    .out_valid_o (out_valid),
    .out_data_o  (read_data_o),
    .pop_i       (pop)
  );

  assign empty = !out_valid;

endmodule

`default_nettype wire
